// ===== rtl/msd_pkg.sv =====
// Package for the masked string decoder: key table size, header and mask codes,
// parse phases and the work entry that travels from the front end to the back end.
// No dependencies.
package msd_pkg;

    localparam int KEY_DEPTH = 65536;
    localparam int KEY_AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_BYTE = 1'b1;

    localparam logic [7:0]  HDR_EMPTY      = 8'h00;
    localparam logic [7:0]  HDR_WIDE_EXT   = 8'h7F;
    localparam logic [7:0]  HDR_NARROW_EXT = 8'h80;
    localparam logic [15:0] MASK_WIDE      = 16'hAAAA;
    localparam logic [15:0] MASK_NARROW    = 16'h00AA;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ENT_KEY  = 2'd0,
        ENT_CHAR = 2'd1,
        ENT_FLAG = 2'd2
    } ent_kind_t;

    typedef struct packed {
        ent_kind_t          kind;
        logic [KEY_AW-1:0]  addr;
        logic [15:0]        data;
        logic               wide;
        logic               empty;
        logic               err;
        logic               last;
    } entry_t;

endpackage

// ===== rtl/msd_front.sv =====
// Front end of the masked string decoder: parses headers and lengths, tracks
// position and mask, and turns beats into work entries for the back end.
// Depends on msd_pkg.
module msd_front import msd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic        op,
    input  logic [15:0] key_address,
    input  logic [7:0]  byte_value,
    output logic        push_valid,
    output entry_t      push_ent
);

    phase_t      phase_reg, phase_next;
    logic        wide_reg, wide_next;
    logic [23:0] len_reg, len_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [16:0] left_reg, left_next;
    logic [16:0] pos_reg, pos_next;
    logic [15:0] mask_reg, mask_next;
    logic [7:0]  low_reg, low_next;

    logic [7:0]  mag;
    logic [31:0] bs_len;
    logic        bs_wide;
    logic [32:0] bs_need;
    logic        bs_empty;
    logic        bs_err;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            wide_reg  <= 1'b0;
            len_reg   <= '0;
            cnt_reg   <= '0;
            left_reg  <= '0;
            pos_reg   <= '0;
            mask_reg  <= MASK_WIDE;
            low_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            wide_reg  <= wide_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            left_reg  <= left_next;
            pos_reg   <= pos_next;
            mask_reg  <= mask_next;
            low_reg   <= low_next;
        end
    end

    // A string start needs the signed length and the character width.
    always_comb begin
        mag      = byte_value[7] ? 8'(~byte_value + 8'd1) : byte_value;
        bs_len   = (phase_reg == PH_LENGTH) ? {byte_value, len_reg} : {24'd0, mag};
        bs_wide  = (phase_reg == PH_LENGTH) ? wide_reg : ~byte_value[7];
        bs_need  = bs_wide ? {bs_len, 1'b0} : {1'b0, bs_len};
        bs_empty = bs_len[31] || (bs_len == 32'd0);
        bs_err   = bs_need > 33'(KEY_DEPTH);
    end

    always_comb begin
        phase_next = phase_reg;
        wide_next  = wide_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        mask_next  = mask_reg;
        low_next   = low_reg;
        push_valid = 1'b0;
        push_ent   = '{kind: ENT_FLAG, addr: '0, data: '0, wide: 1'b0,
                       empty: 1'b0, err: 1'b0, last: 1'b1};

        if (accept && op == OP_KEY) begin
            if ({1'b0, key_address} < 17'(KEY_DEPTH)) begin
                push_valid    = 1'b1;
                push_ent.kind = ENT_KEY;
                push_ent.addr = key_address[KEY_AW-1:0];
                push_ent.data = {8'd0, byte_value};
            end
        end else if (accept) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (byte_value == HDR_EMPTY) begin
                        push_valid     = 1'b1;
                        push_ent.empty = 1'b1;
                    end else if (byte_value == HDR_WIDE_EXT ||
                                 byte_value == HDR_NARROW_EXT) begin
                        wide_next  = ~byte_value[7];
                        len_next   = '0;
                        cnt_next   = '0;
                        phase_next = PH_LENGTH;
                    end else begin
                        wide_next = bs_wide;
                    end
                end
                PH_LENGTH: begin
                    case (cnt_reg)
                        2'd0:    len_next[7:0]   = byte_value;
                        2'd1:    len_next[15:8]  = byte_value;
                        2'd2:    len_next[23:16] = byte_value;
                        default: len_next        = len_reg;
                    endcase
                    cnt_next = 2'(cnt_reg + 2'd1);
                    if (cnt_reg != 2'd3) begin
                        phase_next = PH_LENGTH;
                    end
                end
                PH_PAYLOAD: begin
                    if (wide_reg && !pos_reg[0]) begin
                        low_next = byte_value;
                        pos_next = 17'(pos_reg + 17'd1);
                    end else begin
                        push_valid    = 1'b1;
                        push_ent.kind = ENT_CHAR;
                        push_ent.addr = pos_reg[KEY_AW-1:0];
                        push_ent.wide = wide_reg;
                        push_ent.last = (left_reg == 17'd1);
                        if (wide_reg) begin
                            push_ent.data = {byte_value, low_reg} ^ mask_reg;
                            mask_next     = 16'(mask_reg + 16'd1);
                        end else begin
                            push_ent.data = {8'd0, byte_value ^ mask_reg[7:0]};
                            mask_next     = {8'd0, 8'(mask_reg[7:0] + 8'd1)};
                        end
                        pos_next  = 17'(pos_reg + 17'd1);
                        left_next = 17'(left_reg - 17'd1);
                        if (left_reg == 17'd1) begin
                            phase_next = PH_HEADER;
                        end
                    end
                end
                default: begin
                    phase_next = PH_HEADER;
                end
            endcase

            // Start of a string, from a short header or the last length byte.
            if ((phase_reg == PH_HEADER && byte_value != HDR_EMPTY &&
                 byte_value != HDR_WIDE_EXT && byte_value != HDR_NARROW_EXT) ||
                (phase_reg == PH_LENGTH && cnt_reg == 2'd3)) begin
                if (bs_empty || bs_err) begin
                    push_valid     = 1'b1;
                    push_ent.wide  = bs_wide;
                    push_ent.empty = bs_empty;
                    push_ent.err   = ~bs_empty;
                    phase_next     = PH_HEADER;
                end else begin
                    left_next  = bs_len[16:0];
                    pos_next   = '0;
                    mask_next  = bs_wide ? MASK_WIDE : MASK_NARROW;
                    phase_next = PH_PAYLOAD;
                end
            end
        end
    end

endmodule

// ===== rtl/msd_queue.sv =====
// Short entry queue between the front end and the back end of the decoder.
// Depends on msd_pkg.
module msd_queue import msd_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_ent,
    input  logic   pop,
    output logic   q_valid,
    output logic   q_full,
    output entry_t q_ent
);

    entry_t          slots [QDEPTH];
    logic [QAW-1:0]  wr_reg, rd_reg;
    logic [QAW:0]    count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= QAW'(wr_reg + 1'b1);
            end
            if (pop) begin
                rd_reg <= QAW'(rd_reg + 1'b1);
            end
            count_reg <= (QAW+1)'(count_reg + (QAW+1)'(push) - (QAW+1)'(pop));
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_reg] <= push_ent;
        end
    end

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == (QAW+1)'(QDEPTH));
    assign q_ent   = slots[rd_reg];

endmodule

// ===== rtl/msd_back.sv =====
// Back end of the decoder: key table memory, key lookup stage and result register.
// Depends on msd_pkg.
module msd_back import msd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  entry_t      q_ent,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    logic [7:0]  key_mem [KEY_DEPTH];
    logic [7:0]  key_a_reg, key_b_reg;
    logic        s1_valid_reg;
    entry_t      s1_ent_reg;
    logic        out_valid_reg;
    logic [15:0] code_reg;
    logic [2:0]  flags_reg;
    logic        last_reg;
    logic        out_load;
    logic        s1_take;
    logic [15:0] code;

    assign out_load = !out_valid_reg || m_tready;
    assign s1_take  = !s1_valid_reg || out_load;
    assign pop      = q_valid && s1_take;

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (q_ent.kind == ENT_KEY) begin
                key_mem[q_ent.addr] <= q_ent.data[7:0];
            end
            key_a_reg <= key_mem[q_ent.addr];
            key_b_reg <= key_mem[q_ent.addr - KEY_AW'(1)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= (pop && q_ent.kind != ENT_KEY) || (s1_valid_reg && !out_load);
            if (out_load) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_ent_reg <= q_ent;
        end
        if (out_load && s1_valid_reg) begin
            code_reg  <= code;
            flags_reg <= {s1_ent_reg.err, s1_ent_reg.empty, s1_ent_reg.wide};
            last_reg  <= s1_ent_reg.last;
        end
    end

    always_comb begin
        if (s1_ent_reg.kind == ENT_CHAR) begin
            code = s1_ent_reg.data ^ (s1_ent_reg.wide ? {key_a_reg, key_b_reg}
                                                      : {8'd0, key_a_reg});
        end else begin
            code = s1_ent_reg.data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = code_reg;
    assign m_tuser  = flags_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== rtl/masked_string_decoder.sv =====
// Top level of the masked string decoder: front end, entry queue and back end.
// Depends on msd_pkg, msd_front, msd_queue and msd_back.
//
//   Channel  Direction  Payload
//   s_       in         tdata: key_address[15:0], byte_value[23:16]; tuser: op
//   m_       out        tdata: char_code[15:0]; tuser: wide_char, empty_string,
//                       length_error; tlast: last
//
// One beat is accepted per cycle while the four-entry queue has room.
// A result is registered in the queue, then in the key table read, then in the result register.
// Key writes pass through the same queue, so they stay ordered with key reads.
// Reset clears parsing state and the queue; the key table holds no reset value.
// A stall on the result side fills the queue, then drops s_tready.
module masked_string_decoder import msd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // key_address[15:0], byte_value[23:16]
    input  logic [0:0]  s_tuser,   // op[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // char_code[15:0]
    output logic [2:0]  m_tuser,   // wide_char[0], empty_string[1], length_error[2]
    output logic        m_tlast
);

    logic   accept;
    logic   push_valid;
    entry_t push_ent;
    logic   q_valid;
    logic   q_full;
    entry_t q_ent;
    logic   pop;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    msd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .op          (s_tuser[0]),
        .key_address (s_tdata[15:0]),
        .byte_value  (s_tdata[23:16]),
        .push_valid  (push_valid),
        .push_ent    (push_ent)
    );

    msd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push_valid),
        .push_ent (push_ent),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_full   (q_full),
        .q_ent    (q_ent)
    );

    msd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ent    (q_ent),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> !q_full)
        else $error("Entry pushed into a full queue.");

    a_flag_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[1] || m_tuser[2])) |-> (m_tlast && m_tdata == 16'd0))
        else $error("Empty or error result without last or with a character.");

    a_flag_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[1] && m_tuser[2]))
        else $error("Result flagged both empty and length error.");
`endif

endmodule
